// File: hdl/fqdt_pkg.sv
// Shared constants, types and reset values for the decimating Q15 FIR filter.
package fqdt_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int TAP_COUNT    = 8;
  localparam int DECIM_FACTOR = 16;

  localparam int COEF_W    = 16;
  localparam int COEF_REGS = 8;
  localparam int Q_SHIFT   = 15;

  localparam int PROD_W    = SAMPLE_BITS + 1 + COEF_W;
  localparam int TREE_LVLS = $clog2(TAP_COUNT);
  localparam int TREE_N    = 1 << TREE_LVLS;
  localparam int ACC_W     = PROD_W + TREE_LVLS;
  localparam int SHIFT_W   = ACC_W - Q_SHIFT;

  localparam int PHASE_W   = (DECIM_FACTOR > 1) ? $clog2(DECIM_FACTOR) : 1;

  localparam int APB_DW    = 32;
  localparam int CIDX_W    = $clog2(COEF_REGS);
  localparam int PADDR_W   = CIDX_W + 2;

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [PHASE_W-1:0]        phase_t;
  typedef logic [CIDX_W-1:0]         cidx_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

  localparam coef_t COEF_RESET [COEF_REGS] = '{
    16'sd570, 16'sd2006, 16'sd5445, 16'sd8363,
    16'sd8363, 16'sd5445, 16'sd2006, 16'sd570
  };

endpackage

// File: hdl/fqdt_if.sv
// Valid/ready channel interfaces for samples in and decimated results out.
interface fqdt_in_if;
  import fqdt_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface fqdt_out_if;
  import fqdt_pkg::*;

  logic    valid;
  logic    ready;
  sample_t raw_sample;
  sample_t filtered_sample;

  modport source (output valid, output raw_sample, output filtered_sample, input ready);
  modport sink (input valid, input raw_sample, input filtered_sample, output ready);
endinterface

// File: hdl/fir_q15_decimated_tap.sv
// Top level of the decimating 8-tap Q15 FIR filter.
//
//   port     dir  protocol   payload
//   in_i     in   valid/rdy  sample_in (16b unsigned)
//   out_o    out  valid/rdy  raw_sample, filtered_sample (16b unsigned each)
//   APB      in   psel/pen   coef_0 .. coef_7 at byte address 4*i
//
// One sample is taken every cycle, except that a sample that yields a result waits while
// the product stage is stalled; results pass the product, adder tree and output registers.
// Every DECIM_FACTOR-th sample, starting with the first, yields a result.
// Reset clears the delay line, the phase count and all stage valids, and
// loads the coefficient reset weights. A stalled output holds the pipeline
// stage by stage; skipped samples are still taken while the tree is full.
module fir_q15_decimated_tap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fqdt_in_if.sink                      in_i,
  fqdt_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fqdt_pkg::PADDR_W-1:0] paddr,
  input  logic [fqdt_pkg::APB_DW-1:0]  pwdata,
  output logic [fqdt_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import fqdt_pkg::*;

  coef_t              coef_w  [COEF_REGS];
  sample_t            chain_w [TAP_COUNT];
  prod_t              prod_w  [TAP_COUNT];
  cell_ctrl_t         cell_ctrl;

  phase_t             phase_q;
  phase_t             phase_d;
  logic               emit_now;
  logic               accept;
  logic               en_prod;
  logic               prod_v_q;
  sample_t            prod_raw_q;

  logic               tree_ready;
  logic               tree_valid;
  sample_t            tree_raw;
  acc_t               tree_sum;

  logic               en_out;
  logic               out_v_q;
  sample_t            out_raw_q;
  sample_t            out_filt_q;
  sample_t            filt_d;
  logic signed [SHIFT_W-1:0] shifted;

  fqdt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef_w)
  );

  assign emit_now   = (phase_q == '0);
  assign en_prod    = !prod_v_q || tree_ready;
  assign in_i.ready = emit_now ? en_prod : 1'b1;
  assign accept     = in_i.valid && in_i.ready;

  assign cell_ctrl.shift_en = accept;
  assign cell_ctrl.load_en  = accept && emit_now;

  assign chain_w[0] = in_i.sample_in;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    if (k < TAP_COUNT - 1) begin : g_mid
      fqdt_tap_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (cell_ctrl),
        .coef_i   (coef_w[k]),
        .sample_i (chain_w[k]),
        .sample_o (chain_w[k+1]),
        .prod_o   (prod_w[k])
      );
    end else begin : g_last
      fqdt_tap_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (cell_ctrl),
        .coef_i   (coef_w[k]),
        .sample_i (chain_w[k]),
        .sample_o (),
        .prod_o   (prod_w[k])
      );
    end
  end

  always_comb begin
    if (phase_q == phase_t'(DECIM_FACTOR - 1)) begin
      phase_d = '0;
    end else begin
      phase_d = phase_q + phase_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      prod_v_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
      end
      if (en_prod) begin
        prod_v_q <= cell_ctrl.load_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_ctrl.load_en) begin
      prod_raw_q <= in_i.sample_in;
    end
  end

  fqdt_add_tree u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_v_q),
    .ready_o (tree_ready),
    .raw_i   (prod_raw_q),
    .prod_i  (prod_w),
    .valid_o (tree_valid),
    .ready_i (en_out),
    .raw_o   (tree_raw),
    .sum_o   (tree_sum)
  );

  assign shifted = tree_sum[ACC_W-1:Q_SHIFT];

  always_comb begin
    if (shifted[SHIFT_W-1]) begin
      filt_d = '0;
    end else if (|shifted[SHIFT_W-2:SAMPLE_BITS]) begin
      filt_d = '1;
    end else begin
      filt_d = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign en_out = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= tree_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && tree_valid) begin
      out_raw_q  <= tree_raw;
      out_filt_q <= filt_d;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.raw_sample      = out_raw_q;
  assign out_o.filtered_sample = out_filt_q;

endmodule

// File: hdl/fqdt_cfg_regs.sv
// APB coefficient register file with reset weights.
module fqdt_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fqdt_pkg::PADDR_W-1:0] paddr,
  input  logic [fqdt_pkg::APB_DW-1:0]  pwdata,
  output logic [fqdt_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output fqdt_pkg::coef_t              coef_o [fqdt_pkg::COEF_REGS]
);
  import fqdt_pkg::*;

  coef_t coef_q [COEF_REGS];
  cidx_t idx;
  coef_t rd_coef;
  logic  wr_en;

  assign idx     = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign rd_coef = coef_q[idx];
  assign prdata  = {{(APB_DW-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEF_REGS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (wr_en) begin
      coef_q[idx] <= coef_t'(pwdata[COEF_W-1:0]);
    end
  end

  assign coef_o = coef_q;

endmodule

// File: hdl/fqdt_tap_cell.sv
// One filter tap: delay-line sample register and registered coefficient product.
module fqdt_tap_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fqdt_pkg::cell_ctrl_t ctrl_i,
  input  fqdt_pkg::coef_t      coef_i,
  input  fqdt_pkg::sample_t    sample_i,
  output fqdt_pkg::sample_t    sample_o,
  output fqdt_pkg::prod_t      prod_o
);
  import fqdt_pkg::*;

  sample_t sample_q;
  prod_t   prod_q;
  prod_t   prod_d;
  prod_t   op_a;
  prod_t   op_b;

  assign op_a   = $signed({{(PROD_W-SAMPLE_BITS){1'b0}}, sample_i});
  assign op_b   = $signed({{(PROD_W-COEF_W){coef_i[COEF_W-1]}}, coef_i});
  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctrl_i.shift_en) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en) begin
      prod_q <= prod_d;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

// File: hdl/fqdt_add_tree.sv
// Registered binary adder tree over the tap products, one level per stage.
module fqdt_add_tree (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fqdt_pkg::sample_t raw_i,
  input  fqdt_pkg::prod_t   prod_i [fqdt_pkg::TAP_COUNT],
  output logic              valid_o,
  input  logic              ready_i,
  output fqdt_pkg::sample_t raw_o,
  output fqdt_pkg::acc_t    sum_o
);
  import fqdt_pkg::*;

  acc_t                 node_w [2*TREE_N-1];
  acc_t                 sum_q  [TREE_N-1];
  logic [TREE_LVLS-1:0] v_q;
  sample_t              raw_q  [TREE_LVLS];
  logic [TREE_LVLS:0]   stg_en;

  always_comb begin
    stg_en[TREE_LVLS] = ready_i;
    for (int s = TREE_LVLS - 1; s >= 0; s--) begin
      stg_en[s] = !v_q[s] || stg_en[s+1];
    end
  end

  for (genvar j = 0; j < TREE_N; j++) begin : g_leaf
    if (j < TAP_COUNT) begin : g_tap
      assign node_w[TREE_N-1+j] = {{TREE_LVLS{prod_i[j][PROD_W-1]}}, prod_i[j]};
    end else begin : g_pad
      assign node_w[TREE_N-1+j] = '0;
    end
  end

  for (genvar i = 0; i < TREE_N - 1; i++) begin : g_node
    localparam int STG = TREE_LVLS - $clog2(i + 2);
    assign node_w[i] = sum_q[i];
    always_ff @(posedge clk_i) begin
      if (stg_en[STG]) begin
        sum_q[i] <= node_w[2*i+1] + node_w[2*i+2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < TREE_LVLS; s++) begin
        if (stg_en[s]) begin
          v_q[s] <= (s == 0) ? valid_i : v_q[(s > 0) ? s - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < TREE_LVLS; s++) begin
      if (stg_en[s]) begin
        raw_q[s] <= (s == 0) ? raw_i : raw_q[(s > 0) ? s - 1 : 0];
      end
    end
  end

  assign ready_o = stg_en[0];
  assign valid_o = v_q[TREE_LVLS-1];
  assign raw_o   = raw_q[TREE_LVLS-1];
  assign sum_o   = sum_q[0];

endmodule

// File: sim/fqdt_result_checker.sv
// Checker for the decimating Q15 FIR filter: predicts every result item and compares.
`timescale 1ns / 1ps

module fqdt_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fqdt_in_if                           in_mon_i,
  fqdt_out_if                          out_mon_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [fqdt_pkg::PADDR_W-1:0] paddr_i,
  input  logic [fqdt_pkg::APB_DW-1:0]  pwdata_i,
  input  logic                         pready_i,
  output int                           pending_o,
  output int                           errors_o
);
  import fqdt_pkg::*;

  typedef struct packed {
    sample_t raw;
    sample_t filtered;
  } pair_t;

  localparam longint SAMPLE_MAX = (longint'(1) << SAMPLE_BITS) - 1;

  coef_t   weights [COEF_REGS];
  sample_t history [TAP_COUNT-1];
  phase_t  slot;
  pair_t   expected_pairs [$];
  pair_t   want;
  int      mismatches;

  function automatic pair_t filter_sample(sample_t x);
    longint acc;
    longint y;
    pair_t  p;
    acc = longint'(weights[0]) * longint'(x);
    for (int k = 1; k < TAP_COUNT; k++) begin
      acc += longint'(weights[k]) * longint'(history[k-1]);
    end
    y = acc >>> Q_SHIFT;
    if (y < 0) begin
      p.filtered = '0;
    end else if (y > SAMPLE_MAX) begin
      p.filtered = '1;
    end else begin
      p.filtered = sample_t'(y);
    end
    p.raw = x;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights = COEF_RESET;
      for (int k = 0; k < TAP_COUNT-1; k++) begin
        history[k] = '0;
      end
      slot = '0;
      expected_pairs.delete();
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        weights[cidx_t'(paddr_i >> 2)] = coef_t'(pwdata_i[COEF_W-1:0]);
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (slot == '0) begin
          expected_pairs.push_back(filter_sample(in_mon_i.sample_in));
        end
        for (int k = TAP_COUNT-2; k > 0; k--) begin
          history[k] = history[k-1];
        end
        history[0] = in_mon_i.sample_in;
        slot = (slot == phase_t'(DECIM_FACTOR-1)) ? '0 : slot + 1'b1;
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got raw %h filtered %h",
                   $time, out_mon_i.raw_sample, out_mon_i.filtered_sample);
          mismatches++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_mon_i.raw_sample !== want.raw) begin
            $display("%0t: raw_sample mismatch, expected %h, got %h",
                     $time, want.raw, out_mon_i.raw_sample);
            mismatches++;
          end
          if (out_mon_i.filtered_sample !== want.filtered) begin
            $display("%0t: filtered_sample mismatch, expected %h, got %h",
                     $time, want.filtered, out_mon_i.filtered_sample);
            mismatches++;
          end
        end
      end
    end
    pending_o = expected_pairs.size();
    errors_o  = mismatches;
  end

endmodule

// File: sim/fir_q15_decimated_tap_tb.sv
// Testbench top for the decimating Q15 FIR filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fir_q15_decimated_tap_tb;
  import fqdt_pkg::*;

  typedef enum int {
    SET_MAX,
    SET_MIN,
    SET_RANDOM,
    SET_MODERATE,
    SET_DEFAULT,
    SET_ALTERNATE
  } coef_set_e;

  localparam int CHUNK_ITEMS   = 96;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;

  localparam sample_t DIRECTED [23] = '{
    16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
    16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  localparam coef_set_e CHUNK_SETS [6] = '{
    SET_MAX, SET_MIN, SET_RANDOM, SET_MODERATE, SET_ALTERNATE, SET_DEFAULT
  };

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int pending_items;
  int checker_errors;
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_armed;
  bit hold_served;

  fqdt_in_if  in_ch ();
  fqdt_out_if out_ch ();

  fir_q15_decimated_tap i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fqdt_result_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_ch),
    .out_mon_i (out_ch),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .pready_i  (pready),
    .pending_o (pending_items),
    .errors_o  (checker_errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic sample_t pick_sample();
    int b;
    b = $urandom_range(SAMPLE_BITS-1);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return sample_t'(1) << b;
      3: return ~(sample_t'(1) << b);
      default: return sample_t'($urandom_range(65535));
    endcase
  endfunction

  task automatic write_coef(input int idx, input coef_t value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(idx) << 2;
    pwdata  = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_coef_set(input coef_set_e set);
    coef_t value;
    for (int k = 0; k < COEF_REGS; k++) begin
      case (set)
        SET_MAX:       value = coef_t'(32767);
        SET_MIN:       value = coef_t'(-32768);
        SET_RANDOM:    value = coef_t'($urandom_range(65535));
        SET_MODERATE:  value = coef_t'(int'($urandom_range(8000)) - 2000);
        SET_ALTERNATE: value = (k % 2 == 0) ? coef_t'(32767) : coef_t'(-32768);
        default:       value = COEF_RESET[k];
      endcase
      write_coef(k, value);
    end
  endtask

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = s;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_items != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_served) begin
        hold_served  = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    hold_armed      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      send_sample(DIRECTED[i]);
    end

    for (int c = 0; c < 6; c++) begin
      wait_idle();
      load_coef_set(CHUNK_SETS[c]);
      src_idle_pct = (c < 2) ? 35 : (c < 4) ? 73 : 0;
      snk_idle_pct = (c < 2) ? 73 : (c < 4) ? 35 : 0;
      if (c == 4) begin
        hold_armed = 1'b1;
      end
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        send_sample(pick_sample());
      end
    end

    in_ch.valid = 1'b0;
    while (pending_items != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (checker_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fqdt_pkg.sv
hdl/fqdt_if.sv
hdl/fqdt_cfg_regs.sv
hdl/fqdt_tap_cell.sv
hdl/fqdt_add_tree.sv
hdl/fir_q15_decimated_tap.sv
sim/fqdt_result_checker.sv
sim/fir_q15_decimated_tap_tb.sv
